// ----- src/quadrature_position_decoder_defines.svh -----
// Assertion macros for the quadrature position decoder.
// Included by the RTL files that carry concurrent checks; depends on nothing.
`ifndef QUADRATURE_POSITION_DECODER_DEFINES_SVH
`define QUADRATURE_POSITION_DECODER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset.
`define QPD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define QPD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define QPD_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define QPD_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ----- src/qpd_pkg.sv -----
// Shared types and constants for the quadrature position decoder.
// No dependencies; imported by qpd_step and the top level.
`timescale 1ns / 1ps

package qpd_pkg;

   localparam int unsigned POS_W   = 32;
   localparam int unsigned PHASE_W = 2;

   // Phase difference codes, (new - old) mod 4
   localparam logic [PHASE_W-1:0] STEP_HOLD = 2'd0;
   localparam logic [PHASE_W-1:0] STEP_UP   = 2'd1;
   localparam logic [PHASE_W-1:0] STEP_JUMP = 2'd2;
   localparam logic [PHASE_W-1:0] STEP_DOWN = 2'd3;

   typedef struct packed {
      logic line_a;
      logic line_b;
      logic line_a_inverted;
      logic line_b_inverted;
      logic zero_request;
   } req_type;

   typedef struct packed {
      logic signed [POS_W-1:0] position;
      logic                    zeroed;
      logic                    sequence_error;
      logic                    integrity_error;
   } rsp_type;

   // Decoder state carried between beats
   typedef struct packed {
      logic signed [POS_W-1:0] position;
      logic [PHASE_W-1:0]      phase;
      logic                    sequence_error;
      logic                    integrity_error;
      logic                    zeroed;
   } state_type;

endpackage

// ----- src/qpd_step.sv -----
// Next-state logic for one sample of the encoder lines.
// Depends on qpd_pkg.
`timescale 1ns / 1ps

module qpd_step
   import qpd_pkg::*;
(
   input  state_type cur,
   input  req_type   sample,
   input  logic      check_enable,
   output state_type nxt
);

   logic [PHASE_W-1:0] phase;
   logic [PHASE_W-1:0] step;
   logic               integrity_fail;

   // Gray to binary: {A, A^B}
   assign phase = {sample.line_a, sample.line_a ^ sample.line_b};
   assign step  = phase - cur.phase;

   assign integrity_fail = check_enable &&
                           ((sample.line_a_inverted == sample.line_a) ||
                            (sample.line_b_inverted == sample.line_b));

   always_comb begin
      nxt       = cur;
      nxt.phase = phase;
      case (step)
         STEP_HOLD: nxt.position = cur.position;
         STEP_UP:   nxt.position = cur.position + 32'sd1;
         STEP_DOWN: nxt.position = cur.position - 32'sd1;
         STEP_JUMP: nxt.sequence_error = 1'b1;
         default:   nxt.position = cur.position;
      endcase
      if (integrity_fail) begin
         nxt.integrity_error = 1'b1;
      end
      if (sample.zero_request) begin
         nxt.position = '0;
         nxt.zeroed   = 1'b1;
      end
   end

endmodule

// ----- src/quadrature_position_decoder.sv -----
// Top level of the x4 quadrature position decoder, one axis.
// Depends on qpd_pkg, qpd_step and quadrature_position_decoder_defines.svh.
`timescale 1ns / 1ps
`include "quadrature_position_decoder_defines.svh"

//  channel | ports                                | beat
//  --------+--------------------------------------+----------------------------------
//  req     | req_valid, req_stall, req_data       | one sample of A, B, /A, /B, zero
//  rsp     | rsp_valid, rsp_stall, rsp_data       | position and sticky flags
//  csr     | csr_valid, csr_ready, csr_wdata      | differential check enable
//
//  One sample per cycle while req_stall is low; its result appears in the cycle after acceptance.
//  The result passes through the single rsp register; the step logic is a 32-bit increment or decrement.
//  req_stall is high only while the rsp register holds a beat and rsp_stall is high.
//  Synchronous reset clears position, phase (A=0, B=0), flags and check enable.
//  csr_ready is always high.

module quadrature_position_decoder
   import qpd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data,
   input  logic    csr_valid,
   output logic    csr_ready,
   input  logic    csr_wdata
);

   // Decoder state
   state_type state_ff, state_in;
   // Result register
   logic      rsp_valid_ff, rsp_valid_in;
   rsp_type   rsp_data_ff, rsp_data_in;
   // Configuration
   logic      check_en_ff, check_en_in;

   logic      req_accept;

   // Input blocks only when a held result is not being drained
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   assign csr_ready   = 1'b1;
   assign check_en_in = (csr_valid && csr_ready) ? csr_wdata : check_en_ff;

   qpd_step u_step (
      .cur          (state_ff),
      .sample       (req_data),
      .check_enable (check_en_ff),
      .nxt          (state_in)
   );

   assign rsp_valid_in = req_accept || req_stall;

   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (req_accept) begin
         rsp_data_in.position        = state_in.position;
         rsp_data_in.zeroed          = state_in.zeroed;
         rsp_data_in.sequence_error  = state_in.sequence_error;
         rsp_data_in.integrity_error = state_in.integrity_error;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         check_en_ff  <= 1'b0;
      end else begin
         if (req_accept) begin
            state_ff <= state_in;
         end
         rsp_valid_ff <= rsp_valid_in;
         check_en_ff  <= check_en_in;
      end
   end

   // Payload register, no reset needed
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Checks
   `QPD_ASSERT_NEXT(a_accept_gives_rsp, clock, reset, req_accept, rsp_valid_ff, "accepted beat produced no result")
   `QPD_ASSERT_NEXT(a_zero_clears, clock, reset, req_accept && req_data.zero_request, (rsp_data_ff.position == '0) && rsp_data_ff.zeroed, "zero request did not clear position")
   `QPD_ASSERT_NEXT(a_seq_sticky, clock, reset, state_ff.sequence_error, state_ff.sequence_error, "sequence error flag dropped")
   `QPD_ASSERT_NEXT(a_int_sticky, clock, reset, state_ff.integrity_error, state_ff.integrity_error, "integrity error flag dropped")
   `QPD_ASSERT_IMP(a_rsp_tracks_state, clock, reset, rsp_valid_ff, rsp_data_ff.position == state_ff.position, "result position out of step with state")

endmodule
